>>> design/psf_pkg.sv
// Package with the shared sizes and state codes of the prime sieve filter.
`timescale 1ns / 1ps

package psf_pkg;

  // Table depth and the width of the tested values.
  localparam int unsigned MaxStages = 16;
  localparam int unsigned ValueBits = 16;

  // Derived widths for the table index, the fill count and the bit counter.
  localparam int unsigned IndexBits = (MaxStages > 1) ? $clog2(MaxStages) : 1;
  localparam int unsigned CountBits = $clog2(MaxStages + 1);
  localparam int unsigned BitCntBits = $clog2(ValueBits);

  // Sequencer state codes.
  localparam int unsigned StateBits = 2;
  localparam logic [StateBits-1:0] StIdle = 2'd0;
  localparam logic [StateBits-1:0] StDiv  = 2'd1;
  localparam logic [StateBits-1:0] StEmit = 2'd2;

  typedef logic [ValueBits-1:0] value_t;

endpackage

>>> design/prime_sieve_filter.sv
// Top level of the prime sieve filter: trial division against a table of survivors.
`timescale 1ns / 1ps

// Usage notes.
// Input channel: candidate_i with in_valid_i; the block drives in_stall_o.
// A beat is taken when valid is high and stall is low. A zero candidate ends
// the stream: it yields an end-mark result and empties the table.
// Output channel: prime_value_o, end_mark_o and table_full_o with out_valid_o;
// the receiver drives out_stall_i. At most one result beat per candidate; a
// candidate divisible by a stored value yields no beat at all.
// Timing: one candidate at a time. A nonzero candidate is checked against each
// stored value in turn in the shared restoring divider (one remainder bit per
// cycle, per stored divisor) and then emitted; a full table holds sixteen entries.
// The result sits in an output register, so the next candidate is accepted
// while a finished result still waits; a further result waits in the emit
// step until the receiver drops stall.
// Reset empties the table, clears the output valid and returns to idle.
module prime_sieve_filter (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_stall_o,
  input  logic [15:0]            candidate_i,
  output logic                   out_valid_o,
  input  logic                   out_stall_i,
  output logic [15:0]            prime_value_o,
  output logic                   end_mark_o,
  output logic                   table_full_o
);
  import psf_pkg::*;

  logic [StateBits-1:0]  state_q, state_d;
  value_t                table_q [MaxStages];
  logic [CountBits-1:0]  count_q, count_d;
  logic [IndexBits-1:0]  idx_q, idx_d;
  logic [BitCntBits-1:0] bit_q, bit_d;
  value_t                cand_q, cand_d;
  value_t                rem_q, rem_d;
  logic                  end_q, end_d;
  logic                  out_valid_q, out_valid_d;
  value_t                res_value_q, res_value_d;
  logic                  res_end_q, res_end_d;
  logic                  res_full_q, res_full_d;
  logic                  tbl_we;

  logic                  in_accept;
  logic                  out_free;
  value_t                cand_in;
  value_t                divisor;
  logic [ValueBits:0]    trial;
  logic [ValueBits:0]    trial_sub;
  value_t                rem_next;
  logic                  full;

  assign in_stall_o = (state_q != StIdle);
  assign in_accept  = in_valid_i && (state_q == StIdle);
  assign out_free   = !out_valid_q || !out_stall_i;
  assign cand_in    = candidate_i[ValueBits-1:0];
  assign full       = (count_q >= CountBits'(MaxStages));

  // One step of the shared restoring divider: shift in a dividend bit and subtract.
  assign divisor   = table_q[idx_q];
  assign trial     = {rem_q, cand_q[bit_q]};
  assign trial_sub = trial - {1'b0, divisor};
  assign rem_next  = (trial >= {1'b0, divisor}) ? trial_sub[ValueBits-1:0]
                                                : trial[ValueBits-1:0];

  // Sequencer over table entries and remainder bits.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    bit_d       = bit_q;
    cand_d      = cand_q;
    rem_d       = rem_q;
    end_d       = end_q;
    out_valid_d = out_valid_q && out_stall_i;
    res_value_d = res_value_q;
    res_end_d   = res_end_q;
    res_full_d  = res_full_q;
    tbl_we      = 1'b0;

    unique case (state_q)
      StIdle: begin
        if (in_accept) begin
          cand_d = cand_in;
          idx_d  = '0;
          rem_d  = '0;
          bit_d  = BitCntBits'(ValueBits - 1);
          if (cand_in == '0) begin
            end_d   = 1'b1;
            state_d = StEmit;
          end else if (count_q == '0) begin
            end_d   = 1'b0;
            state_d = StEmit;
          end else begin
            end_d   = 1'b0;
            state_d = StDiv;
          end
        end
      end
      StDiv: begin
        rem_d = rem_next;
        bit_d = bit_q - 1'b1;
        if (bit_q == '0) begin
          // Last remainder bit of this divisor is known.
          if ((rem_next == '0) && (divisor != '0)) begin
            state_d = StIdle;
          end else if (({1'b0, idx_q} + 1'b1) == count_q) begin
            state_d = StEmit;
          end else begin
            idx_d = idx_q + 1'b1;
            rem_d = '0;
            bit_d = BitCntBits'(ValueBits - 1);
          end
        end
      end
      StEmit: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          state_d     = StIdle;
          if (end_q) begin
            res_value_d = '0;
            res_end_d   = 1'b1;
            res_full_d  = 1'b0;
            count_d     = '0;
          end else begin
            res_value_d = cand_q;
            res_end_d   = 1'b0;
            res_full_d  = full;
            if (!full) begin
              tbl_we  = 1'b1;
              count_d = count_q + 1'b1;
            end
          end
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Working and result registers.
  always_ff @(posedge clk_i) begin
    idx_q       <= idx_d;
    bit_q       <= bit_d;
    cand_q      <= cand_d;
    rem_q       <= rem_d;
    end_q       <= end_d;
    res_value_q <= res_value_d;
    res_end_q   <= res_end_d;
    res_full_q  <= res_full_d;
  end

  // Table of stored survivors, appended at the fill count.
  always_ff @(posedge clk_i) begin
    if (tbl_we) begin
      table_q[count_q[IndexBits-1:0]] <= cand_q;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign prime_value_o = res_value_q;
  assign end_mark_o    = res_end_q;
  assign table_full_o  = res_full_q;

endmodule

>>> tb/sv/prime_sieve_filter_chk.sv
// Checker for the prime sieve filter: keeps its own survivor table and compares each result beat.
`timescale 1ns / 1ps

module prime_sieve_filter_chk (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic            in_stall_i,
  input  psf_pkg::value_t candidate_i,
  input  logic            out_valid_i,
  input  logic            out_stall_i,
  input  psf_pkg::value_t prime_value_i,
  input  logic            end_mark_i,
  input  logic            table_full_i,
  output int unsigned     fail_count_o,
  output int unsigned     pending_o
);
  import psf_pkg::*;

  typedef struct packed {
    value_t prime_value;
    logic   end_mark;
    logic   table_full;
  } sieve_result_t;

  // Survivors seen since the last end of stream, in arrival order.
  value_t        survivor_table [MaxStages];
  int unsigned   survivor_count;
  sieve_result_t awaited_results [$];

  always @(posedge clk_i or negedge rst_ni) begin : watch
    sieve_result_t want;
    logic          divisible;
    if (!rst_ni) begin
      awaited_results.delete();
      survivor_count = 0;
      fail_count_o   = 0;
      pending_o      = 0;
    end else begin
      // Result beats are compared first: a beat can never answer the candidate
      // taken at the same edge.
      if (out_valid_i && !out_stall_i) begin
        if (awaited_results.size() == 0) begin
          fail_count_o++;
          $display("%0t ns: result beat with none expected: value %0d end %0b full %0b",
                   $time, prime_value_i, end_mark_i, table_full_i);
        end else begin
          want = awaited_results.pop_front();
          if (prime_value_i !== want.prime_value) begin
            fail_count_o++;
            $display("%0t ns: prime_value expected %0d, got %0d",
                     $time, want.prime_value, prime_value_i);
          end
          if (end_mark_i !== want.end_mark) begin
            fail_count_o++;
            $display("%0t ns: end_mark expected %0b, got %0b",
                     $time, want.end_mark, end_mark_i);
          end
          if (table_full_i !== want.table_full) begin
            fail_count_o++;
            $display("%0t ns: table_full expected %0b, got %0b",
                     $time, want.table_full, table_full_i);
          end
        end
      end

      // A zero closes the stream; any other candidate survives unless a stored
      // value divides it, and a survivor is kept only while there is room.
      if (in_valid_i && !in_stall_i) begin
        if (candidate_i == '0) begin
          survivor_count   = 0;
          want.prime_value = '0;
          want.end_mark    = 1'b1;
          want.table_full  = 1'b0;
          awaited_results.push_back(want);
        end else begin
          divisible = 1'b0;
          for (int k = 0; k < survivor_count; k++) begin
            if (survivor_table[k] != '0 && (candidate_i % survivor_table[k]) == '0)
              divisible = 1'b1;
          end
          if (!divisible) begin
            want.prime_value = candidate_i;
            want.end_mark    = 1'b0;
            want.table_full  = (survivor_count >= MaxStages);
            if (!want.table_full) begin
              survivor_table[survivor_count] = candidate_i;
              survivor_count++;
            end
            awaited_results.push_back(want);
          end
        end
      end
      pending_o = awaited_results.size();
    end
  end

endmodule

>>> tb/sv/prime_sieve_filter_tb.sv
// Testbench top for the prime sieve filter: clock, reset, stimulus and the verdict.
`timescale 1ns / 1ps

module prime_sieve_filter_tb;
  import psf_pkg::*;

  localparam int unsigned TotalItems  = 650;
  localparam int unsigned IdlePercent = 27;
  localparam int unsigned CycleLimit  = 1_000_000;
  localparam int unsigned DrainCycles = 300;

  // Opening items: end mark on an empty table, the candidate one swallowing the
  // rest of its stream, the extreme values, a divisible candidate, and a table
  // filled to the brim with one survivor too many.
  localparam int unsigned OpeningCount = 23;
  localparam value_t OpeningItems [OpeningCount] = '{
    16'd0, 16'd1, 16'd7, 16'd0,
    16'd65535, 16'd32768, 16'd2, 16'd4,
    16'd3, 16'd5, 16'd7, 16'd11, 16'd13, 16'd17, 16'd19, 16'd23,
    16'd29, 16'd31, 16'd37, 16'd41, 16'd43, 16'd47, 16'd0
  };

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        in_valid   = 1'b0;
  logic        in_stall;
  value_t      candidate  = '0;
  logic        out_valid;
  logic        out_stall  = 1'b0;
  value_t      prime_value;
  logic        end_mark;
  logic        table_full;
  int unsigned fail_count;
  int unsigned pending;

  int unsigned sent_items = 0;
  logic        steady     = 1'b0;

  prime_sieve_filter uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_o   (in_stall),
    .candidate_i  (candidate),
    .out_valid_o  (out_valid),
    .out_stall_i  (out_stall),
    .prime_value_o(prime_value),
    .end_mark_o   (end_mark),
    .table_full_o (table_full)
  );

  prime_sieve_filter_chk sieve_check (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .candidate_i  (candidate),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .prime_value_i(prime_value),
    .end_mark_i   (end_mark),
    .table_full_i (table_full),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // The receiver stalls at random, except through the steady stretch.
  always @(negedge clk) begin
    out_stall <= !steady && ($urandom_range(0, 99) < IdlePercent);
  end

  // Present one candidate beat, after a random gap, and hold it until taken.
  task automatic offer_candidate(input value_t value);
    steady = (sent_items >= 250 && sent_items < 400);
    while (!steady && $urandom_range(0, 99) < IdlePercent) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    candidate <= value;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_items++;
    @(negedge clk);
  endtask

  // Drop valid and wait until every expected result beat has been taken.
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  initial begin : watchdog
    repeat (CycleLimit) @(posedge clk);
    $display("prime_sieve_filter_tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    int unsigned pick;
    int unsigned run_len;
    value_t      start;
    logic        paused;
    paused = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    foreach (OpeningItems[i]) offer_candidate(OpeningItems[i]);
    hold_until_drained();

    while (sent_items < TotalItems) begin
      pick = $urandom_range(0, 99);
      if (pick < 70) begin
        // Well-formed stream: mostly a counting run from a small or large
        // start, with the odd jump, closed by a zero.
        start   = ($urandom_range(0, 3) == 0) ? value_t'($urandom_range(2, 65535))
                                                : value_t'($urandom_range(2, 60));
        run_len = $urandom_range(4, 50);
        for (int i = 0; i < run_len; i++) begin
          if ($urandom_range(0, 15) == 0)
            start = value_t'($urandom_range(1, 65535));
          offer_candidate(start);
          start = start + 1'b1;
        end
        offer_candidate('0);
      end else if (pick < 85) begin
        // Noise: arbitrary values over the full range, zero now and then.
        run_len = $urandom_range(1, 12);
        for (int i = 0; i < run_len; i++)
          offer_candidate(($urandom_range(0, 7) == 0) ? value_t'(0)
                                                      : value_t'($urandom_range(0, 65535)));
      end else begin
        // Broken stream: a one slipped in swallows what follows; the stream
        // is sometimes left open.
        run_len = $urandom_range(1, 8);
        for (int i = 0; i < run_len; i++)
          offer_candidate(value_t'($urandom_range(2, 65535)));
        offer_candidate(16'd1);
        run_len = $urandom_range(1, 6);
        for (int i = 0; i < run_len; i++)
          offer_candidate(value_t'($urandom_range(1, 65535)));
        if ($urandom_range(0, 1) == 0)
          offer_candidate('0);
      end

      if (!paused && sent_items >= 500) begin
        paused = 1'b1;
        hold_until_drained();
      end
    end

    hold_until_drained();
    repeat (DrainCycles) @(posedge clk);
    if (fail_count == 0)
      $display("prime_sieve_filter_tb: done, clean");
    else
      $display("prime_sieve_filter_tb: done, errors");
    $finish;
  end

endmodule

>>> filelist.f
design/psf_pkg.sv
design/prime_sieve_filter.sv
tb/sv/prime_sieve_filter_chk.sv
tb/sv/prime_sieve_filter_tb.sv
